FILE: rtl/wavhp_pkg.sv
// Shared constants and types of the WAV header parser and sample assembler.
package wavhp_pkg;

   // Header layout: checks fall on the byte that completes each field
   localparam logic [5:0] HDR_LEN      = 6'd44;
   localparam logic [5:0] POS_RIFF     = 6'd4;
   localparam logic [5:0] POS_SIZE     = 6'd8;
   localparam logic [5:0] POS_WAVE     = 6'd12;
   localparam logic [5:0] POS_FMT      = 6'd16;
   localparam logic [5:0] POS_CHANNELS = 6'd24;
   localparam logic [5:0] POS_RATE     = 6'd28;
   localparam logic [5:0] POS_BITS     = 6'd36;
   localparam logic [5:0] POS_DATA     = 6'd40;

   // Magic words as seen in the window, first character in the lowest byte
   localparam logic [31:0] WORD_RIFF = 32'h4646_4952;
   localparam logic [31:0] WORD_WAVE = 32'h4556_4157;
   localparam logic [31:0] WORD_FMT  = 32'h2074_6D66;
   localparam logic [31:0] WORD_DATA = 32'h6174_6164;

   localparam logic [31:0] RATE_8K    = 32'h0000_1F40;
   localparam logic [31:0] RATE_16K   = 32'h0000_3E80;
   localparam logic [31:0] RATE_44K1  = 32'h0000_AC44;
   localparam logic [15:0] CHAN_MONO   = 16'h0001;
   localparam logic [15:0] CHAN_STEREO = 16'h0002;
   localparam logic [15:0] BITS_8      = 16'h0008;
   localparam logic [15:0] BITS_16     = 16'h0010;

   localparam logic [31:0] SIZE_OFFSET = 32'd36;

   localparam logic [1:0] RATE_CODE_8K   = 2'd0;
   localparam logic [1:0] RATE_CODE_16K  = 2'd1;
   localparam logic [1:0] RATE_CODE_44K1 = 2'd2;

   // Register map
   localparam int unsigned   CSR_ADDR_W      = 3;
   localparam logic [2:0]    CSR_ENABLE_ADDR = 3'd0;

   typedef enum logic [2:0] {
      PH_IGNORED = 3'd0,
      PH_HEADER  = 3'd1,
      PH_ERROR   = 3'd2,
      PH_ACCEPT  = 3'd3,
      PH_DATA    = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        start_event;
      logic        sample_valid;
      logic [15:0] sample_value;
      logic        end_event;
      logic        channel_code;
      logic [1:0]  rate_code;
      logic        bits_code;
      logic [31:0] data_size;
   } rsp_type;

endpackage

FILE: rtl/wav_header_parser_sample_assembler.sv
// WAV header parser and sample assembler: one byte in, one result out per transfer.
// Result: the result of each accepted byte is loaded into the output register on its transfer and shown on rsp_.
// Throughput: one byte per cycle; a single output register parts the two channels and
//    req_tready stays high while that register is empty or being taken.
// Reset: synchronous, clears enable, all parser state and the output valid flag.
// Bytes accepted while enable is zero give a phase-ignored result and leave state alone.
module wav_header_parser_sample_assembler (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] start_event, [1] sample_valid, [17:2] sample_value, [18] channel_code,
   // [20:19] rate_code, [21] bits_code, [53:22] data_size, [55:54] zero
   output logic [55:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] phase
   output logic        rsp_tlast,   // end_event
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [wavhp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic               enable_ff;
   logic               receiving_ff,  receiving_in;
   logic [5:0]         header_count_ff, header_count_in;
   logic [31:0]        window_ff,     window_in;
   logic [31:0]        announced_ff,  announced_in;
   logic [31:0]        data_count_ff, data_count_in;
   logic [7:0]         accum_ff,      accum_in;
   logic               chan_ff,       chan_in;
   logic [1:0]         rate_ff,       rate_in;
   logic               width_ff,      width_in;
   logic               rsp_valid_ff;
   wavhp_pkg::rsp_type rsp_ff,        rsp_in;

   logic               req_xfer;
   logic               csr_write;
   logic [31:0]        window_shift;
   logic [5:0]         count_inc;
   logic [15:0]        half;
   logic               hdr_ok;

   assign req_xfer   = req_tvalid & req_tready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register read-back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == wavhp_pkg::CSR_ENABLE_ADDR) begin
         csr_prdata = {31'd0, enable_ff};
      end
   end

   // Work out the next parser state and the result of the offered byte
   always_comb begin
      receiving_in    = receiving_ff;
      header_count_in = header_count_ff;
      window_in       = window_ff;
      announced_in    = announced_ff;
      data_count_in   = data_count_ff;
      accum_in        = accum_ff;
      chan_in         = chan_ff;
      rate_in         = rate_ff;
      width_in        = width_ff;
      rsp_in          = '0;
      rsp_in.phase    = wavhp_pkg::PH_IGNORED;
      window_shift    = {req_tdata, window_ff[31:8]};
      count_inc       = header_count_ff + 6'd1;
      half            = window_shift[31:16];
      hdr_ok          = 1'b1;

      if (enable_ff) begin
         if (!receiving_ff) begin
            // Header: shift the byte in and check the field it completes
            window_in       = window_shift;
            header_count_in = count_inc;
            unique case (count_inc)
               wavhp_pkg::POS_RIFF: hdr_ok = (window_shift == wavhp_pkg::WORD_RIFF);
               wavhp_pkg::POS_SIZE: announced_in = window_shift - wavhp_pkg::SIZE_OFFSET;
               wavhp_pkg::POS_WAVE: hdr_ok = (window_shift == wavhp_pkg::WORD_WAVE);
               wavhp_pkg::POS_FMT:  hdr_ok = (window_shift == wavhp_pkg::WORD_FMT);
               wavhp_pkg::POS_CHANNELS: begin
                  if (half == wavhp_pkg::CHAN_MONO) begin
                     chan_in = 1'b0;
                  end else if (half == wavhp_pkg::CHAN_STEREO) begin
                     chan_in = 1'b1;
                  end else begin
                     hdr_ok = 1'b0;
                  end
               end
               wavhp_pkg::POS_RATE: begin
                  if (window_shift == wavhp_pkg::RATE_8K) begin
                     rate_in = wavhp_pkg::RATE_CODE_8K;
                  end else if (window_shift == wavhp_pkg::RATE_16K) begin
                     rate_in = wavhp_pkg::RATE_CODE_16K;
                  end else if (window_shift == wavhp_pkg::RATE_44K1) begin
                     rate_in = wavhp_pkg::RATE_CODE_44K1;
                  end else begin
                     hdr_ok = 1'b0;
                  end
               end
               wavhp_pkg::POS_BITS: begin
                  if (half == wavhp_pkg::BITS_8) begin
                     width_in = 1'b0;
                  end else if (half == wavhp_pkg::BITS_16) begin
                     width_in = 1'b1;
                  end else begin
                     hdr_ok = 1'b0;
                  end
               end
               wavhp_pkg::POS_DATA: hdr_ok = (window_shift == wavhp_pkg::WORD_DATA);
               default: hdr_ok = 1'b1;
            endcase

            if (!hdr_ok) begin
               // Drop the attempt and start over with the next byte
               receiving_in    = 1'b0;
               header_count_in = '0;
               window_in       = '0;
               announced_in    = '0;
               data_count_in   = '0;
               accum_in        = '0;
               chan_in         = 1'b0;
               rate_in         = '0;
               width_in        = 1'b0;
               rsp_in.phase    = wavhp_pkg::PH_ERROR;
            end else if (count_inc >= wavhp_pkg::HDR_LEN) begin
               receiving_in        = 1'b1;
               header_count_in     = '0;
               data_count_in       = '0;
               accum_in            = '0;
               rsp_in.phase        = wavhp_pkg::PH_ACCEPT;
               rsp_in.channel_code = chan_in;
               rsp_in.rate_code    = rate_in;
               rsp_in.bits_code    = width_in;
               rsp_in.data_size    = announced_in;
            end else begin
               rsp_in.phase = wavhp_pkg::PH_HEADER;
            end
         end else begin
            // Data: pack bytes little-endian into samples
            rsp_in.phase        = wavhp_pkg::PH_DATA;
            rsp_in.channel_code = chan_ff;
            rsp_in.rate_code    = rate_ff;
            rsp_in.bits_code    = width_ff;
            rsp_in.data_size    = announced_ff;
            rsp_in.start_event  = (data_count_ff == '0);
            if (width_ff && !data_count_ff[0]) begin
               accum_in = req_tdata;
            end else begin
               rsp_in.sample_valid = 1'b1;
               rsp_in.sample_value = width_ff ? {req_tdata, accum_ff} : {8'd0, req_tdata};
               accum_in            = '0;
            end
            data_count_in = data_count_ff + 32'd1;
            if (data_count_in >= announced_ff) begin
               // Last announced byte: back to header parsing, drop a partial sample
               rsp_in.end_event = 1'b1;
               receiving_in     = 1'b0;
               header_count_in  = '0;
               window_in        = '0;
               announced_in     = '0;
               data_count_in    = '0;
               accum_in         = '0;
               chan_in          = 1'b0;
               rate_in          = '0;
               width_in         = 1'b0;
            end
         end
      end
   end

   // Hold parser state; advance it on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         receiving_ff    <= 1'b0;
         header_count_ff <= '0;
         window_ff       <= '0;
         announced_ff    <= '0;
         data_count_ff   <= '0;
         accum_ff        <= '0;
         chan_ff         <= 1'b0;
         rate_ff         <= '0;
         width_ff        <= 1'b0;
      end else begin
         if (csr_write && csr_paddr == wavhp_pkg::CSR_ENABLE_ADDR) begin
            enable_ff <= csr_pwdata[0];
         end
         if (req_xfer) begin
            receiving_ff    <= receiving_in;
            header_count_ff <= header_count_in;
            window_ff       <= window_in;
            announced_ff    <= announced_in;
            data_count_ff   <= data_count_in;
            accum_ff        <= accum_in;
            chan_ff         <= chan_in;
            rate_ff         <= rate_in;
            width_ff        <= width_in;
         end
      end
   end

   // Output register: load on an input transfer, empty when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.phase;
   assign rsp_tlast  = rsp_ff.end_event;
   assign rsp_tdata  = {2'd0, rsp_ff.data_size, rsp_ff.bits_code, rsp_ff.rate_code,
                        rsp_ff.channel_code, rsp_ff.sample_value, rsp_ff.sample_valid,
                        rsp_ff.start_event};

   // Header position never reaches the full header length while parsing
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> header_count_ff < wavhp_pkg::HDR_LEN)
      else $error("header count out of range");

   // Events and samples appear only on data bytes
   a_data_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.phase != wavhp_pkg::PH_DATA |->
         !rsp_ff.start_event && !rsp_ff.end_event && !rsp_ff.sample_valid)
      else $error("event outside data phase");

   // End of data returns the parser to header parsing
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && rsp_in.end_event |=> !receiving_ff && data_count_ff == '0)
      else $error("parser not cleared after end of data");

   // Accepting a header enters the data phase with a fresh count
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_xfer && rsp_in.phase == wavhp_pkg::PH_ACCEPT |=>
         receiving_ff && data_count_ff == '0 && header_count_ff == '0)
      else $error("header accept did not enter data phase");

endmodule

FILE: verif/wav_parse_check_pkg.sv
// Scoreboard for the WAV header parser: predicts each result from the bytes taken and checks it.
package wav_parse_check_pkg;
   import wavhp_pkg::*;

   class wav_parse_scoreboard;
      // predicted parser state
      bit          enabled;
      bit          in_data;
      bit [5:0]    hdr_count;
      bit [31:0]   window;
      bit [31:0]   announced;
      bit [1:0]    sample_bytes;
      bit [31:0]   data_count;
      bit [15:0]   accum;
      bit          chan_code;
      bit [1:0]    rate_code;
      bit          width_code;

      rsp_type     awaited_results[$];

      int          mismatches;
      int          active_bytes;
      int          ignored_bytes;
      int          headers_accepted;
      int          header_errors;
      int          samples_done;
      int          streams_ended;

      function new();
         enabled = 1'b0;
         clear_parser();
      endfunction

      function void clear_parser();
         in_data      = 1'b0;
         hdr_count    = '0;
         window       = '0;
         announced    = '0;
         sample_bytes = '0;
         data_count   = '0;
         accum        = '0;
         chan_code    = 1'b0;
         rate_code    = '0;
         width_code   = 1'b0;
      endfunction

      function void set_enable(bit value);
         enabled = value;
      endfunction

      function bit at_header_start();
         return !in_data && hdr_count == 6'd0;
      endfunction

      function int pending_count();
         return awaited_results.size();
      endfunction

      // Check the field that the newest byte completes; latch decoded settings
      function bit header_field_ok();
         bit [15:0] half;
         half = window[31:16];
         case (hdr_count)
            POS_RIFF: return window == WORD_RIFF;
            POS_SIZE: begin
               announced = window - SIZE_OFFSET;
               return 1'b1;
            end
            POS_WAVE: return window == WORD_WAVE;
            POS_FMT:  return window == WORD_FMT;
            POS_CHANNELS: begin
               if (half == CHAN_MONO) begin
                  chan_code = 1'b0;
                  return 1'b1;
               end
               if (half == CHAN_STEREO) begin
                  chan_code = 1'b1;
                  return 1'b1;
               end
               return 1'b0;
            end
            POS_RATE: begin
               if (window == RATE_8K) begin
                  rate_code = RATE_CODE_8K;
                  return 1'b1;
               end
               if (window == RATE_16K) begin
                  rate_code = RATE_CODE_16K;
                  return 1'b1;
               end
               if (window == RATE_44K1) begin
                  rate_code = RATE_CODE_44K1;
                  return 1'b1;
               end
               return 1'b0;
            end
            POS_BITS: begin
               if (half == BITS_8) begin
                  width_code   = 1'b0;
                  sample_bytes = 2'd1;
                  return 1'b1;
               end
               if (half == BITS_16) begin
                  width_code   = 1'b1;
                  sample_bytes = 2'd2;
                  return 1'b1;
               end
               return 1'b0;
            end
            POS_DATA: return window == WORD_DATA;
            default:  return 1'b1;
         endcase
      endfunction

      function rsp_type with_stream_info(rsp_type r);
         r.channel_code = chan_code;
         r.rate_code    = rate_code;
         r.bits_code    = width_code;
         r.data_size    = announced;
         return r;
      endfunction

      // Advance the predicted parser by one accepted byte and queue its result
      function void take_byte(logic [7:0] b);
         rsp_type want;
         bit      pos;
         want = '0;
         if (!enabled) begin
            ignored_bytes++;
            want.phase = PH_IGNORED;
            awaited_results.push_back(want);
            return;
         end
         active_bytes++;
         if (!in_data) begin
            window    = {b, window[31:8]};
            hdr_count = hdr_count + 6'd1;
            if (!header_field_ok()) begin
               clear_parser();
               want.phase = PH_ERROR;
               header_errors++;
            end else if (hdr_count >= HDR_LEN) begin
               in_data    = 1'b1;
               hdr_count  = '0;
               data_count = '0;
               accum      = '0;
               want.phase = PH_ACCEPT;
               want       = with_stream_info(want);
               headers_accepted++;
            end else begin
               want.phase = PH_HEADER;
            end
         end else begin
            pos = (sample_bytes == 2'd2) ? data_count[0] : 1'b0;
            want.phase       = PH_DATA;
            want             = with_stream_info(want);
            want.start_event = (data_count == 32'd0);
            accum = accum | (pos ? {b, 8'h00} : {8'h00, b});
            // a sample completes on its last byte lane
            if (sample_bytes != 2'd2 || pos) begin
               want.sample_valid = 1'b1;
               want.sample_value = accum;
               accum = '0;
               samples_done++;
            end
            data_count = data_count + 32'd1;
            if (data_count >= announced) begin
               want.end_event = 1'b1;
               streams_ended++;
               clear_parser();
            end
         end
         awaited_results.push_back(want);
      endfunction

      function void report(string field, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: %s mismatch, expected %0h, actual %0h",
                        $time, field, want_v, got_v);
         end
      endfunction

      // Compare one transfer on the result channel with the oldest prediction
      function void check_result(logic [55:0] bus, logic [2:0] phase_bits, logic end_flag);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: result with nothing awaited, expected none, actual %0h/%0h",
                        $time, phase_bits, bus);
            return;
         end
         want = awaited_results.pop_front();
         report("phase",        32'(want.phase),        32'(phase_bits));
         report("start_event",  32'(want.start_event),  32'(bus[0]));
         report("sample_valid", 32'(want.sample_valid), 32'(bus[1]));
         report("sample_value", 32'(want.sample_value), 32'(bus[17:2]));
         report("end_event",    32'(want.end_event),    32'(end_flag));
         report("channel_code", 32'(want.channel_code), 32'(bus[18]));
         report("rate_code",    32'(want.rate_code),    32'(bus[20:19]));
         report("bits_code",    32'(want.bits_code),    32'(bus[21]));
         report("data_size",    want.data_size,         bus[53:22]);
      endfunction
   endclass

endpackage

FILE: verif/tb_top.sv
// Top-level testbench of the WAV header parser and sample assembler.
module tb_top;
   import wavhp_pkg::*;
   import wav_parse_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 1450;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [55:0]           rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   wav_parse_scoreboard board;
   logic [7:0]          frame_bytes[$];
   bit                  req_calm;
   bit                  rsp_calm;
   int                  cycles = 0;

   wav_header_parser_sample_assembler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stalls, check every transfer
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Offer one byte after a random gap and hold it until the transfer
   task automatic push_byte(input logic [7:0] value);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.take_byte(value);
   endtask

   // Drain every awaited result, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_ENABLE_ADDR)
         board.set_enable(value[0]);
   endtask

   task automatic put_le(input logic [31:0] value, input int count);
      for (int i = 0; i < count; i++)
         frame_bytes.push_back(value[8*i +: 8]);
   endtask

   // Lay out a 44-byte header followed by random audio bytes
   task automatic build_frame(input logic [15:0] chans, input logic [31:0] rate,
                              input logic [15:0] bits, input logic [31:0] riff_size,
                              input int data_len);
      frame_bytes.delete();
      put_le(WORD_RIFF, 4);
      put_le(riff_size, 4);
      put_le(WORD_WAVE, 4);
      put_le(WORD_FMT, 4);
      put_le(($urandom_range(0, 3) == 0) ? $urandom : 32'd16, 4);
      put_le(($urandom_range(0, 3) == 0) ? $urandom : 32'd1, 2);
      put_le({16'h0000, chans}, 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le({16'h0000, bits}, 2);
      put_le(WORD_DATA, 4);
      put_le($urandom, 4);
      repeat (data_len) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Switch the block off for a few ignored bytes, then back on
   task automatic disabled_interlude();
      wait_idle();
      csr_write(CSR_ENABLE_ADDR, $urandom & 32'hFFFF_FFFE);
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      wait_idle();
      csr_write(CSR_ENABLE_ADDR, $urandom | 32'h1);
   endtask

   // Send the frame, optionally pausing at one byte, then resync the parser
   task automatic send_frame(input int pause_at);
      int tries;
      req_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      foreach (frame_bytes[i]) begin
         if (i == pause_at)
            disabled_interlude();
         push_byte(frame_bytes[i]);
      end
      tries = 0;
      while (!board.at_header_start() && tries < 400) begin
         push_byte(8'($urandom_range(0, 255)));
         tries++;
      end
   endtask

   task automatic run_random_frame();
      int          kind;
      int          size;
      int          idx;
      int          pause_at;
      logic [15:0] chans;
      logic [15:0] bits;
      logic [31:0] rate;
      kind  = $urandom_range(0, 99);
      chans = $urandom_range(0, 1) ? CHAN_STEREO : CHAN_MONO;
      bits  = $urandom_range(0, 1) ? BITS_16 : BITS_8;
      case ($urandom_range(0, 2))
         0:       rate = RATE_8K;
         1:       rate = RATE_16K;
         default: rate = RATE_44K1;
      endcase
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 120) : $urandom_range(0, 16);
      // bad field value in an otherwise sound header
      if (kind >= 70 && kind < 85) begin
         case ($urandom_range(0, 2))
            0:       chans = $urandom_range(0, 1) ? 16'($urandom_range(3, 65535)) : 16'h0000;
            1:       rate  = $urandom_range(0, 1) ? 32'd48000 : $urandom;
            default: bits  = $urandom_range(0, 1) ? 16'd24 : 16'($urandom);
         endcase
      end
      build_frame(chans, rate, bits, size + SIZE_OFFSET, (size == 0) ? 1 : size);
      // flip one bit of a checked header byte
      if (kind >= 85 && kind < 95) begin
         do idx = $urandom_range(0, 39);
         while ((idx >= 4 && idx < 8) || (idx >= 16 && idx < 22) || (idx >= 28 && idx < 34));
         frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      // plain noise between frames
      if (kind >= 95) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
      send_frame(pause_at);
   endtask

   initial begin
      board       = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // bytes offered before the block is switched on are ignored
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h5A);
      wait_idle();
      csr_write(CSR_ENABLE_ADDR, 32'h1);

      // mono, 8-bit samples, 8 kHz, three bytes of audio
      build_frame(CHAN_MONO, RATE_8K, BITS_8, SIZE_OFFSET + 3, 3);
      send_frame(-1);
      // zero data size: one data byte raises start and end together
      build_frame(CHAN_STEREO, RATE_16K, BITS_16, SIZE_OFFSET, 1);
      send_frame(-1);
      // odd byte count with 16-bit samples drops the trailing half sample
      build_frame(CHAN_MONO, RATE_44K1, BITS_16, SIZE_OFFSET + 5, 5);
      frame_bytes[HDR_LEN]     = 8'h00;
      frame_bytes[HDR_LEN + 1] = 8'hFF;
      frame_bytes[HDR_LEN + 2] = 8'hFF;
      frame_bytes[HDR_LEN + 3] = 8'h00;
      frame_bytes[HDR_LEN + 4] = 8'h80;
      send_frame(HDR_LEN + 2);
      // rejected headers: each magic word and each checked field
      build_frame(CHAN_MONO, RATE_8K, BITS_8, SIZE_OFFSET + 2, 2);
      frame_bytes[0] = 8'h72;
      send_frame(-1);
      build_frame(CHAN_MONO, RATE_8K, BITS_8, SIZE_OFFSET + 2, 2);
      frame_bytes[10] = 8'h00;
      send_frame(-1);
      build_frame(CHAN_MONO, RATE_8K, BITS_8, SIZE_OFFSET + 2, 2);
      frame_bytes[15] = 8'h00;
      send_frame(-1);
      build_frame(16'h0003, RATE_8K, BITS_8, SIZE_OFFSET + 2, 2);
      send_frame(-1);
      build_frame(CHAN_STEREO, 32'd48000, BITS_8, SIZE_OFFSET + 2, 2);
      send_frame(-1);
      build_frame(CHAN_STEREO, RATE_16K, 16'd24, SIZE_OFFSET + 2, 2);
      send_frame(-1);
      build_frame(CHAN_STEREO, RATE_16K, BITS_16, SIZE_OFFSET + 2, 2);
      frame_bytes[39] = frame_bytes[39] ^ 8'h01;
      send_frame(-1);

      // random frames, mostly well formed
      while (board.active_bytes < RANDOM_BYTES)
         run_random_frame();

      // size field below the offset wraps to the largest data size
      build_frame(CHAN_STEREO, RATE_44K1, BITS_16, 32'd35, 8);
      foreach (frame_bytes[i])
         push_byte(frame_bytes[i]);

      wait_idle();
      $display("Parsed %0d bytes plus %0d while switched off; %0d headers accepted, %0d rejected",
               board.active_bytes, board.ignored_bytes, board.headers_accepted,
               board.header_errors);
      $display("Assembled %0d samples over %0d completed streams",
               board.samples_done, board.streams_ended);
      if (board.mismatches == 0 && board.pending_count() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
